// ===== rtl/core/bsfn_pkg.sv =====
// Shared types, constants and helper functions for the bitset store with find-next.
package bsfn_pkg;

  // Bitset geometry
  localparam int unsigned LIMB_COUNT_MAX = 16;
  localparam int unsigned LIMB_W         = 64;
  localparam int unsigned LIMB_IDX_W     = 6;
  localparam int unsigned BIT_INDEX_W    = 11;
  localparam int unsigned LIMB_SEL_W     = BIT_INDEX_W - LIMB_IDX_W;
  localparam int unsigned NEXT_W         = 10;
  localparam int unsigned REQ_W          = 3;
  localparam int unsigned CFG_W          = 5;

  localparam logic [CFG_W-1:0] LIMB_COUNT_RST = CFG_W'(16);

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_TEST    = 3'd0,
    REQ_ADD     = 3'd1,
    REQ_DISCARD = 3'd2,
    REQ_FIND    = 3'd3,
    REQ_FIRST_N = 3'd4
  } req_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_RESP
  } state_e;

  // Command broadcast from the controller to every cell
  typedef struct packed {
    logic                  exec;
    req_e                  op;
    logic [LIMB_SEL_W-1:0] limb_sel;
    logic [LIMB_IDX_W-1:0] bit_sel;
    logic [LIMB_SEL_W-1:0] limbs;
    logic [LIMB_SEL_W-1:0] fill_full;
    logic [LIMB_IDX_W-1:0] fill_rem;
  } cmd_t;

  // Per-cell status
  typedef struct packed {
    logic              token;
    logic              pass;
    logic              hit;
    logic              term;
    logic              member;
    logic [NEXT_W-1:0] pos;
  } stat_t;

  // Combined status seen by the controller
  typedef struct packed {
    logic              done;
    logic              found;
    logic              member;
    logic [NEXT_W-1:0] pos;
  } sum_t;

  // Position of the lowest set bit: isolate it, then encode the one-hot word
  function automatic logic [LIMB_IDX_W-1:0] lowest_pos(input logic [LIMB_W-1:0] w);
    logic [LIMB_W-1:0]     iso;
    logic [LIMB_IDX_W-1:0] pos;
    iso = w & (~w + LIMB_W'(1));
    pos = '0;
    for (int k = 0; k < LIMB_W; k++) begin
      if (iso[k]) begin
        pos = pos | LIMB_IDX_W'(k);
      end
    end
    return pos;
  endfunction

endpackage

// ===== rtl/core/bsfn_cell.sv =====
// One limb of the bitset with its slot of the find-next search chain.
module bsfn_cell #(
  parameter int unsigned CellIdx = 0,
  parameter bit          IsLast  = 1'b0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bsfn_pkg::cmd_t   cmd_i,
  input  logic             pass_i,
  output bsfn_pkg::stat_t  stat_o
);
  import bsfn_pkg::*;

  logic [LIMB_W-1:0] limb_q, limb_d;
  logic              token_q, token_d;
  logic              sel, in_use, hit, pass;
  logic [LIMB_W-1:0] bit_m, below_m, fill_m, word;
  logic [LIMB_IDX_W-1:0] lp;

  assign sel     = (32'(cmd_i.limb_sel) == CellIdx);
  assign in_use  = (32'(cmd_i.limbs) > CellIdx);
  assign bit_m   = LIMB_W'(1) << cmd_i.bit_sel;
  assign below_m = ~({LIMB_W{1'b1}} << cmd_i.bit_sel);
  assign fill_m  = ~({LIMB_W{1'b1}} << cmd_i.fill_rem);

  // Limb update and token injection
  always_comb begin
    limb_d  = limb_q;
    token_d = pass_i;
    if (cmd_i.exec) begin
      case (cmd_i.op)
        REQ_ADD: begin
          if (sel) limb_d = limb_q | bit_m;
        end
        REQ_DISCARD: begin
          if (sel) limb_d = limb_q & ~bit_m;
        end
        REQ_FIND: begin
          if (sel) token_d = 1'b1;
        end
        REQ_FIRST_N: begin
          if (in_use) begin
            if (CellIdx < 32'(cmd_i.fill_full)) begin
              limb_d = {LIMB_W{1'b1}};
            end else if (CellIdx == 32'(cmd_i.fill_full)) begin
              limb_d = fill_m;
            end else begin
              limb_d = '0;
            end
          end
        end
        default: begin
          limb_d = limb_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limb_q  <= '0;
      token_q <= 1'b0;
    end else begin
      limb_q  <= limb_d;
      token_q <= token_d;
    end
  end

  // Search step: the starting limb masks off bits below the index
  assign word = limb_q & (sel ? ~below_m : {LIMB_W{1'b1}});
  assign lp   = lowest_pos(word);
  assign hit  = token_q && in_use && (|word);
  assign pass = token_q && in_use && !hit && !IsLast;

  always_comb begin
    stat_o        = '0;
    stat_o.token  = token_q;
    stat_o.pass   = pass;
    stat_o.hit    = hit;
    stat_o.term   = token_q && !pass;
    stat_o.member = sel && limb_q[cmd_i.bit_sel];
    stat_o.pos    = hit ? NEXT_W'((CellIdx << LIMB_IDX_W) | 32'(lp)) : '0;
  end

endmodule

// ===== rtl/core/bsfn_ctrl.sv =====
// Request sequencer: decodes a request, drives the cell row and builds the result.
module bsfn_ctrl #(
  parameter int unsigned LimbCountMax = bsfn_pkg::LIMB_COUNT_MAX
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [bsfn_pkg::REQ_W-1:0]       req_type_i,
  input  logic [bsfn_pkg::BIT_INDEX_W-1:0] bit_index_i,
  input  logic [bsfn_pkg::CFG_W-1:0]       limb_count_i,
  input  bsfn_pkg::sum_t                   sum_i,
  output bsfn_pkg::cmd_t                   cmd_o,
  output logic                             result_valid_o,
  output logic                             is_member_o,
  output logic [bsfn_pkg::NEXT_W-1:0]      next_index_o,
  output logic                             not_found_o,
  output logic                             range_error_o
);
  import bsfn_pkg::*;

  state_e             state_q, state_d;
  cmd_t               cmd_q, cmd_d;
  logic               rerr_q, rerr_d;
  logic               member_q, member_d;
  logic [NEXT_W-1:0]  next_q, next_d;
  logic               nf_q, nf_d;

  logic [LIMB_SEL_W-1:0]  limbs;
  logic [BIT_INDEX_W-1:0] len, fill_n;
  logic                   rerr_in;

  // Limbs in use, clamped to one and to the store size
  always_comb begin
    limbs = (limb_count_i == '0) ? LIMB_SEL_W'(1) : LIMB_SEL_W'(limb_count_i);
    if (32'(limbs) > LimbCountMax) begin
      limbs = LIMB_SEL_W'(LimbCountMax);
    end
  end

  assign len     = {limbs, {LIMB_IDX_W{1'b0}}};
  assign fill_n  = (bit_index_i > len) ? len : bit_index_i;
  assign rerr_in = (req_type_i <= REQ_FIND) &&
                   (bit_index_i[BIT_INDEX_W-1:LIMB_IDX_W] >= limbs);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    rerr_q   <= rerr_d;
    member_q <= member_d;
    next_q   <= next_d;
    nf_q     <= nf_d;
  end

  // Next state and result capture
  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    rerr_d   = rerr_q;
    member_d = member_q;
    next_d   = next_q;
    nf_d     = nf_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_d.exec      = 1'b0;
          cmd_d.op        = req_e'(req_type_i);
          cmd_d.limb_sel  = bit_index_i[BIT_INDEX_W-1:LIMB_IDX_W];
          cmd_d.bit_sel   = bit_index_i[LIMB_IDX_W-1:0];
          cmd_d.limbs     = limbs;
          cmd_d.fill_full = fill_n[BIT_INDEX_W-1:LIMB_IDX_W];
          cmd_d.fill_rem  = fill_n[LIMB_IDX_W-1:0];
          rerr_d          = rerr_in;
          member_d        = 1'b0;
          next_d          = '0;
          nf_d            = 1'b0;
          state_d         = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (rerr_q) begin
          state_d = ST_RESP;
        end else begin
          case (cmd_q.op)
            REQ_TEST: begin
              member_d = sum_i.member;
              state_d  = ST_RESP;
            end
            REQ_FIND: begin
              state_d = ST_SCAN;
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (sum_i.done) begin
          nf_d    = !sum_i.found;
          next_d  = sum_i.pos;
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Command is held for the whole request; it acts only in the execute cycle
  always_comb begin
    cmd_o      = cmd_q;
    cmd_o.exec = (state_q == ST_EXEC) && !rerr_q;
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = (state_q == ST_RESP);
  assign is_member_o    = member_q;
  assign next_index_o   = next_q;
  assign not_found_o    = nf_q;
  assign range_error_o  = rerr_q;

endmodule

// ===== rtl/core/bitset_store_find_next_unit.sv =====
// Top level of the bitset store: limb count register, cell row and sequencer.
//
//  Channel   | Direction | Transfer when
//  ----------+-----------+------------------------------------------------
//  request   | in        | start high and busy low at a rising edge
//  result    | out       | result_valid_o high for one cycle, always taken
//  config    | in        | cfg_we_i high at a rising edge (limb_count)
//
// Test, add, discard and set-first-n: the request goes through the execute state
// to the result state; the next request transfer is possible once busy is low.
// Find-next adds a scan state in which the search token visits one limb after
// another, up to the first hit, the first limb out of use or the last limb.
// Reset clears every limb and sets limb_count to 16; busy is high from the
// request transfer through its result cycle. The result side cannot stall.
module bitset_store_find_next_unit #(
  parameter int unsigned LimbCountMax = bsfn_pkg::LIMB_COUNT_MAX
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [bsfn_pkg::REQ_W-1:0]       req_type_i,
  input  logic [bsfn_pkg::BIT_INDEX_W-1:0] bit_index_i,
  input  logic                             cfg_we_i,
  input  logic [bsfn_pkg::CFG_W-1:0]       cfg_wdata_i,
  output logic                             result_valid_o,
  output logic                             is_member_o,
  output logic [bsfn_pkg::NEXT_W-1:0]      next_index_o,
  output logic                             not_found_o,
  output logic                             range_error_o
);
  import bsfn_pkg::*;

  logic [CFG_W-1:0]        limb_count_q;
  cmd_t                    cmd;
  stat_t                   stat [LimbCountMax];
  logic [LimbCountMax-1:0] pass_in;
  logic [LimbCountMax-1:0] token;
  sum_t                    sum;

  // limb_count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limb_count_q <= LIMB_COUNT_RST;
    end else if (cfg_we_i) begin
      limb_count_q <= cfg_wdata_i;
    end
  end

  // Row of limb cells, the search token moving upwards
  for (genvar i = 0; i < LimbCountMax; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign pass_in[i] = 1'b0;
    end else begin : g_link
      assign pass_in[i] = stat[i-1].pass;
    end

    bsfn_cell #(
      .CellIdx (i),
      .IsLast  (i == LimbCountMax - 1)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .pass_i (pass_in[i]),
      .stat_o (stat[i])
    );

    assign token[i] = stat[i].token;
  end

  // Merge cell status; at most one cell reports at a time
  always_comb begin
    sum = '0;
    for (int i = 0; i < LimbCountMax; i++) begin
      sum.done   = sum.done   | stat[i].term;
      sum.found  = sum.found  | stat[i].hit;
      sum.member = sum.member | stat[i].member;
      sum.pos    = sum.pos    | stat[i].pos;
    end
  end

  bsfn_ctrl #(
    .LimbCountMax (LimbCountMax)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type_i),
    .bit_index_i    (bit_index_i),
    .limb_count_i   (limb_count_q),
    .sum_i          (sum),
    .cmd_o          (cmd),
    .result_valid_o (result_valid_o),
    .is_member_o    (is_member_o),
    .next_index_o   (next_index_o),
    .not_found_o    (not_found_o),
    .range_error_o  (range_error_o)
  );

`ifndef SYNTHESIS
  // Only one search token in the row at any time
  a_token_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(token))
    else $error("more than one search token in the cell row");

  // A result is a single-cycle strobe
  a_result_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held longer than one cycle");

  // A range error carries no other result
  a_rerr_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && range_error_o) |->
      (!is_member_o && !not_found_o && next_index_o == '0))
    else $error("range error result carries other fields");

  // No token left over once the result is out
  a_token_gone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (token == '0))
    else $error("search token still live at result");
`endif

endmodule
